// ----- hdl/sqm_pkg.sv -----
// Shared definitions for the sorted queue with merge of the two smallest entries.
// Holds the default depth, status codes, the cell control struct and the saturating add.
// No dependencies; every other file refers to it by scoped names.
package sqm_pkg;

  localparam int unsigned QueueDepthDef = 1024;
  localparam int unsigned EntryW = 64;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountOutW = 11;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_MERGE  = 1'b1;

  typedef struct packed {
    logic ins;
    logic pop2;
  } cell_ctrl_t;

  function automatic logic [EntryW-1:0] sat_add(input logic [EntryW-1:0] a,
                                                input logic [EntryW-1:0] b);
    logic [EntryW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[EntryW] ? {EntryW{1'b1}} : s[EntryW-1:0];
  endfunction

endpackage

// ----- hdl/sqm_cell.sv -----
// One cell of the sorted row: holds a single entry and trades it with its neighbors.
// Depends on sqm_pkg for the entry width and the cell control struct.
module sqm_cell (
  input  logic                      clk_i,
  input  sqm_pkg::cell_ctrl_t       ctrl_i,
  input  logic [sqm_pkg::EntryW-1:0] x_i,
  input  logic                      occ_i,
  input  logic [sqm_pkg::EntryW-1:0] prev_val_i,
  input  logic                      prev_gt_i,
  input  logic [sqm_pkg::EntryW-1:0] next2_val_i,
  output logic [sqm_pkg::EntryW-1:0] val_o,
  output logic                      gt_o
);

  logic [sqm_pkg::EntryW-1:0] val_q, val_d;

  // An empty cell acts as an entry larger than any value.
  assign gt_o  = !occ_i || (val_q > x_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.pop2) begin
      val_d = next2_val_i;
    end else if (ctrl_i.ins) begin
      if (prev_gt_i) begin
        val_d = prev_val_i;
      end else if (gt_o) begin
        val_d = x_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ----- hdl/sorted_queue_merge_two_smallest_core.sv -----
// Top level of the sorted queue with merge: control sequencer and the row of cells.
// Depends on sqm_pkg and sqm_cell.
//
// The input channel carries one item: func_i selects insert or merge, value_i
// is the value to insert. Each item yields exactly one result item on the output
// channel: the running total, the entry count, the smallest entry and a status.
// Entries live in a row of QUEUE_DEPTH cells kept in ascending order. An insert
// shifts every cell above the insertion point one place up, all cells together.
// A merge shifts the row down by two while the two smallest are summed, then
// inserts the sum twice, one cell-row shift per cycle.
// An insert passes through S_INS2 and S_DONE, a refused item through S_DONE only,
// and a merge through S_POP, S_INS1, S_INS2 and S_DONE; the result is registered
// on leaving S_DONE. The sequencer takes one item at a time: a new item is only
// accepted once the last one has left S_DONE and the sequencer is back in S_IDLE.
// A new item is accepted while a finished result still waits in the output
// register; if the receiver stalls, the next result waits in the sequencer.
// Reset empties the store and clears the total; entry values need no reset.
module sorted_queue_merge_two_smallest_core #(
  parameter int unsigned QUEUE_DEPTH = sqm_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [sqm_pkg::ValueW-1:0]   value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sqm_pkg::EntryW-1:0]   total_o,
  output logic [sqm_pkg::CountOutW-1:0] entry_count_o,
  output logic [sqm_pkg::EntryW-1:0]   smallest_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = sqm_pkg::EntryW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_POP  = 5'b00010,
    S_INS1 = 5'b00100,
    S_INS2 = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [EW-1:0] total_q, total_d;
  logic [EW-1:0] x_q, x_d;
  logic [1:0] status_q, status_d;

  logic out_valid_q;
  logic [EW-1:0] out_total_q, out_small_q;
  logic [CountW-1:0] out_count_q;
  logic [1:0] out_status_q;

  sqm_pkg::cell_ctrl_t ctrl;
  logic [EW-1:0] val [QUEUE_DEPTH];
  logic gt [QUEUE_DEPTH];
  logic occ [QUEUE_DEPTH];

  logic in_acc;
  logic out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign ctrl.pop2 = (state_q == S_POP);
  assign ctrl.ins  = (state_q == S_INS1) || (state_q == S_INS2);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [EW-1:0] prev_val, next2_val;
    logic prev_gt;

    assign occ[i] = (count_q > CountW'(i));

    if (i == 0) begin : g_first
      assign prev_val = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_val = val[i-1];
      assign prev_gt  = gt[i-1];
    end

    if (i + 2 < QUEUE_DEPTH) begin : g_has_next
      assign next2_val = val[i+2];
    end else begin : g_end
      assign next2_val = '0;
    end

    sqm_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .x_i         (x_q),
      .occ_i       (occ[i]),
      .prev_val_i  (prev_val),
      .prev_gt_i   (prev_gt),
      .next2_val_i (next2_val),
      .val_o       (val[i]),
      .gt_o        (gt[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    total_d  = total_q;
    x_d      = x_q;
    status_d = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x_d = EW'(value_i);
          status_d = sqm_pkg::ST_DONE;
          if (func_i == sqm_pkg::FUNC_INSERT) begin
            if (count_q == CountW'(QUEUE_DEPTH)) begin
              status_d = sqm_pkg::ST_FULL;
              state_d = S_DONE;
            end else begin
              state_d = S_INS2;
            end
          end else begin
            if (count_q < CountW'(2)) begin
              status_d = sqm_pkg::ST_SHORT;
              state_d = S_DONE;
            end else begin
              state_d = S_POP;
            end
          end
        end
      end
      S_POP: begin
        x_d = sqm_pkg::sat_add(val[0], val[1]);
        count_d = count_q - CountW'(2);
        state_d = S_INS1;
      end
      S_INS1: begin
        count_d = count_q + CountW'(1);
        state_d = S_INS2;
      end
      S_INS2: begin
        count_d = count_q + CountW'(1);
        total_d = sqm_pkg::sat_add(total_q, x_q);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      total_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      total_q  <= total_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    status_q <= status_d;
    if (state_q == S_DONE && out_free) begin
      out_total_q  <= total_q;
      out_count_q  <= count_q;
      out_small_q  <= occ[0] ? val[0] : '0;
      out_status_q <= status_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign total_o       = out_total_q;
  assign entry_count_o = sqm_pkg::CountOutW'(out_count_q);
  assign smallest_o    = out_small_q;
  assign status_o      = out_status_q;

endmodule

// ----- hdl/sqm_checker.sv -----
// Port-level checks for sorted_queue_merge_two_smallest_core, attached by bind.
// Depends on sqm_pkg for widths and status codes.
module sqm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          func_i,
  input logic [sqm_pkg::ValueW-1:0]    value_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [sqm_pkg::EntryW-1:0]    total_o,
  input logic [sqm_pkg::CountOutW-1:0] entry_count_o,
  input logic [sqm_pkg::EntryW-1:0]    smallest_o,
  input logic [1:0]                    status_o
);

  // Only the three defined status codes are ever reported.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == sqm_pkg::ST_DONE || status_o == sqm_pkg::ST_FULL ||
                     status_o == sqm_pkg::ST_SHORT))
    else $error("undefined status code");

  // An empty store reports a smallest entry of zero.
  a_empty_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_count_o == '0) |-> (smallest_o == '0))
    else $error("nonzero smallest with empty store");

  // The block works on one item at a time, so it is busy right after an acceptance.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted two items back to back");

  // A waiting input item holds.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(func_i) && $stable(value_i)))
    else $error("input item changed while waiting");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(total_o) && $stable(entry_count_o) &&
       $stable(smallest_o) && $stable(status_o)))
    else $error("result changed while stalled");

endmodule

bind sorted_queue_merge_two_smallest_core sqm_checker u_sqm_checker (.*);
